>>> design/pfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the postfix expression evaluator: character
// codes, command format between front and back, error codes, ALU handshake.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int SYM_W  = 8;
  localparam int VAL_W  = 64;
  localparam int FRAC_W = 32;
  localparam int DIG_W  = 4;

  localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE = 8'h39;
  localparam logic [SYM_W-1:0] CH_ADD  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_SUB  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV  = 8'h2F;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Depth of the command queue between front and back
  localparam int CMD_Q_DEPTH = 2;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    K_NOP,
    K_DIGIT,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [DIG_W-1:0] digit;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] result;
  } alu_rsp_t;

  // Keep only the first error of an expression
  function automatic err_t raise_err(err_t cur, err_t code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

>>> design/pfe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_in_if / pfe_out_if
// Valid/ready channels of the evaluator: characters in, results out.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  import pfe_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, symbol, last, input ready);
  modport sink   (input valid, symbol, last, output ready);
endinterface

interface pfe_out_if;
  import pfe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic [1:0]              status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

>>> design/pfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_front
// Accepts characters and classifies them into stack commands. Characters
// that do nothing and do not end the expression are dropped here.
// ----------------------------------------------------------------------------
module pfe_front (
  pfe_in_if.sink        in_ch,
  output logic          cmd_valid,
  output pfe_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import pfe_pkg::*;

  logic [SYM_W-1:0] sym_off;

  assign sym_off = in_ch.symbol - CH_ZERO;

  always_comb begin
    cmd.last  = in_ch.last;
    cmd.digit = sym_off[DIG_W-1:0];
    priority if (in_ch.symbol >= CH_ZERO && in_ch.symbol <= CH_NINE) begin
      cmd.kind = K_DIGIT;
    end else if (in_ch.symbol == CH_ADD) begin
      cmd.kind = K_ADD;
    end else if (in_ch.symbol == CH_SUB) begin
      cmd.kind = K_SUB;
    end else if (in_ch.symbol == CH_MUL) begin
      cmd.kind = K_MUL;
    end else if (in_ch.symbol == CH_DIV) begin
      cmd.kind = K_DIV;
    end else begin
      cmd.kind = K_NOP;
    end
  end

  assign in_ch.ready = cmd_ready;
  // drop ignored characters unless they close the expression
  assign cmd_valid   = in_ch.valid && ((cmd.kind != K_NOP) || in_ch.last);

endmodule

>>> design/pfe_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pfe_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  input  pfe_pkg::cmd_t wr_data,
  output logic          wr_ready,
  output logic          rd_valid,
  output pfe_pkg::cmd_t rd_data,
  input  logic          rd_ready
);
  import pfe_pkg::*;

  localparam int AW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int CW = $clog2(CMD_Q_DEPTH + 1);

  cmd_t          entry_r [CMD_Q_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r;
  logic          do_wr, do_rd;

  assign wr_ready = (fill_r != CW'(CMD_Q_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    rd_ptr_nxt = (rd_ptr_r == AW'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (do_wr && !do_rd) begin
        fill_r <= fill_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill_r <= fill_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/pfe_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_alu
// Multicycle Q32.32 multiply and divide with saturation. Multiply runs four
// 32x32 partial products; divide is restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfe_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  pfe_pkg::alu_req_t req,
  output pfe_pkg::alu_rsp_t rsp
);
  import pfe_pkg::*;

  localparam int HALF_W = VAL_W / 2;
  localparam int PROD_W = 2 * VAL_W;
  localparam int IT_W   = $clog2(VAL_W);
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] MUL_LAST = 3'd4;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV_PREP,
    A_DIV,
    A_SAT
  } astate_t;

  astate_t             state_r;
  logic                neg_r;
  logic                is_div_r;
  logic [VAL_W-1:0]    ma_r, mb_r;
  logic [STEP_W-1:0]   step_r;
  logic [VAL_W-1:0]    prod_r;
  logic [1:0]          sh_r;
  logic                prod_vld_r;
  logic [PROD_W-1:0]   acc_r;
  logic [VAL_W-1:0]    rem_r;
  logic [HALF_W-1:0]   num_r;
  logic [VAL_W-1:0]    q_r;
  logic [IT_W-1:0]     it_r;
  logic                ovf_r;
  logic                done_r;
  logic [VAL_W-1:0]    res_r;

  logic [HALF_W-1:0]   op_a, op_b;
  logic [1:0]          sh_nxt;
  logic [VAL_W-1:0]    prod_nxt;
  logic [PROD_W-1:0]   acc_add;
  logic [VAL_W:0]      trial;
  logic                ge;
  logic [VAL_W-1:0]    m_sel, limit, m_lim, sat_out;
  logic                ovf_sel;

  always_comb begin
    unique case (step_r[1:0])
      2'd0: begin
        op_a = ma_r[HALF_W-1:0]; op_b = mb_r[HALF_W-1:0]; sh_nxt = 2'd0;
      end
      2'd1: begin
        op_a = ma_r[HALF_W-1:0]; op_b = mb_r[VAL_W-1:HALF_W]; sh_nxt = 2'd1;
      end
      2'd2: begin
        op_a = ma_r[VAL_W-1:HALF_W]; op_b = mb_r[HALF_W-1:0]; sh_nxt = 2'd1;
      end
      default: begin
        op_a = ma_r[VAL_W-1:HALF_W]; op_b = mb_r[VAL_W-1:HALF_W]; sh_nxt = 2'd2;
      end
    endcase
    prod_nxt = op_a * op_b;
  end

  always_comb begin
    unique case (sh_r)
      2'd0:    acc_add = {{VAL_W{1'b0}}, prod_r};
      2'd1:    acc_add = {{HALF_W{1'b0}}, prod_r, {HALF_W{1'b0}}};
      default: acc_add = {prod_r, {VAL_W{1'b0}}};
    endcase
  end

  // restoring step: bring in the next numerator bit, subtract when it fits
  assign trial = {rem_r, num_r[HALF_W-1]} - {1'b0, mb_r};
  assign ge    = !trial[VAL_W];

  always_comb begin
    if (is_div_r) begin
      m_sel   = q_r;
      ovf_sel = ovf_r;
    end else begin
      m_sel   = acc_r[FRAC_W +: VAL_W];
      ovf_sel = |acc_r[PROD_W-1:FRAC_W+VAL_W];
    end
    limit   = neg_r ? VAL_MIN : VAL_MAX;
    m_lim   = (ovf_sel || (m_sel > limit)) ? limit : m_sel;
    sat_out = neg_r ? (VAL_W'(0) - m_lim) : m_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == A_SAT);
      unique case (state_r)
        A_IDLE: begin
          if (req.start) begin
            is_div_r   <= req.is_div;
            neg_r      <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
            ma_r       <= req.a[VAL_W-1] ? (VAL_W'(0) - req.a) : req.a;
            mb_r       <= req.b[VAL_W-1] ? (VAL_W'(0) - req.b) : req.b;
            step_r     <= '0;
            prod_vld_r <= 1'b0;
            acc_r      <= '0;
            state_r    <= req.is_div ? A_DIV_PREP : A_MUL;
          end
        end
        A_MUL: begin
          if (prod_vld_r) begin
            acc_r <= acc_r + acc_add;
          end
          if (step_r == MUL_LAST) begin
            prod_vld_r <= 1'b0;
            state_r    <= A_SAT;
          end else begin
            prod_r     <= prod_nxt;
            sh_r       <= sh_nxt;
            prod_vld_r <= 1'b1;
            step_r     <= step_r + STEP_W'(1);
          end
        end
        A_DIV_PREP: begin
          // the quotient reaches 2^64 exactly when the integer part covers the divisor
          ovf_r   <= ({{HALF_W{1'b0}}, ma_r[VAL_W-1:HALF_W]} >= mb_r);
          rem_r   <= {{HALF_W{1'b0}}, ma_r[VAL_W-1:HALF_W]};
          num_r   <= ma_r[HALF_W-1:0];
          q_r     <= '0;
          it_r    <= '0;
          state_r <= ({{HALF_W{1'b0}}, ma_r[VAL_W-1:HALF_W]} >= mb_r) ? A_SAT : A_DIV;
        end
        A_DIV: begin
          rem_r <= ge ? trial[VAL_W-1:0] : {rem_r[VAL_W-2:0], num_r[HALF_W-1]};
          num_r <= {num_r[HALF_W-2:0], 1'b0};
          q_r   <= {q_r[VAL_W-2:0], ge};
          it_r  <= it_r + IT_W'(1);
          if (it_r == {IT_W{1'b1}}) begin
            state_r <= A_SAT;
          end
        end
        A_SAT: begin
          res_r   <= sat_out;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

>>> design/pfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_back
// Executes stack commands on the operand stack memory, drives the ALU and
// registers the final result of each expression.
// ----------------------------------------------------------------------------
module pfe_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  pfe_pkg::cmd_t     cmd,
  output logic              cmd_ready,
  output pfe_pkg::alu_req_t alu_req,
  input  pfe_pkg::alu_rsp_t alu_rsp,
  pfe_out_if.source         out_ch
);
  import pfe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_R,
    S_RD_L,
    S_EXEC,
    S_WAIT,
    S_PUSH,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;

  logic [VAL_W-1:0] stack_mem [STACK_DEPTH];
  logic [VAL_W-1:0] rdata_r;

  state_t           state_r;
  logic [CW-1:0]    cnt_r;
  err_t             err_r;
  kind_t            kind_r;
  logic             last_r;
  logic             right_ok_r, left_ok_r;
  logic [VAL_W-1:0] right_r;
  logic [VAL_W-1:0] res_r;
  logic             alu_start_r;
  logic [VAL_W-1:0] alu_a_r, alu_b_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  err_t             out_status_r;

  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    rd_addr;
  logic             push_we;
  logic [VAL_W-1:0] lval, sum, dif;
  logic             sum_ovf, dif_ovf;
  err_t             fin_err;

  // top of stack is always the read address; the read data is registered and follows in the next cycle
  assign cnt_m1  = cnt_r - CW'(1);
  assign rd_addr = (cnt_r == '0) ? '0 : cnt_m1[AW-1:0];
  assign push_we = (state_r == S_PUSH) && (cnt_r < CW'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (push_we) begin
      stack_mem[cnt_r[AW-1:0]] <= res_r;
    end
    rdata_r <= stack_mem[rd_addr];
  end

  assign lval    = left_ok_r ? rdata_r : '0;
  assign sum     = lval + right_r;
  assign dif     = lval - right_r;
  assign sum_ovf = !(lval[VAL_W-1] ^ right_r[VAL_W-1]) && (lval[VAL_W-1] ^ sum[VAL_W-1]);
  assign dif_ovf = (lval[VAL_W-1] ^ right_r[VAL_W-1]) && (lval[VAL_W-1] ^ dif[VAL_W-1]);
  assign fin_err = (cnt_r == '0) ? raise_err(err_r, ERR_UNDER) : err_r;

  assign cmd_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      alu_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // pulse start for one cycle when a multiply or a nonzero divide issues
      alu_start_r <= (state_r == S_EXEC) &&
                     ((kind_r == K_MUL) || ((kind_r == K_DIV) && (right_r != '0)));
      if ((state_r == S_FIN_OUT) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            kind_r <= cmd.kind;
            last_r <= cmd.last;
            res_r  <= {{(VAL_W-FRAC_W-DIG_W){1'b0}}, cmd.digit, {FRAC_W{1'b0}}};
            unique case (cmd.kind)
              K_DIGIT:                    state_r <= S_PUSH;
              K_ADD, K_SUB, K_MUL, K_DIV: state_r <= S_RD_R;
              default:                    state_r <= cmd.last ? S_FIN_RD : S_IDLE;
            endcase
          end
        end
        S_RD_R: begin
          if (cnt_r != '0) begin
            cnt_r      <= cnt_m1;
            right_ok_r <= 1'b1;
          end else begin
            err_r      <= raise_err(err_r, ERR_UNDER);
            right_ok_r <= 1'b0;
          end
          state_r <= S_RD_L;
        end
        S_RD_L: begin
          right_r <= right_ok_r ? rdata_r : '0;
          if (cnt_r != '0) begin
            cnt_r     <= cnt_m1;
            left_ok_r <= 1'b1;
          end else begin
            err_r     <= raise_err(err_r, ERR_UNDER);
            left_ok_r <= 1'b0;
          end
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          alu_a_r <= lval;
          alu_b_r <= right_r;
          unique case (kind_r)
            K_ADD: begin
              res_r   <= sum_ovf ? (lval[VAL_W-1] ? VAL_MIN : VAL_MAX) : sum;
              state_r <= S_PUSH;
            end
            K_SUB: begin
              res_r   <= dif_ovf ? (lval[VAL_W-1] ? VAL_MIN : VAL_MAX) : dif;
              state_r <= S_PUSH;
            end
            K_MUL: begin
              state_r <= S_WAIT;
            end
            K_DIV: begin
              if (right_r == '0) begin
                err_r   <= raise_err(err_r, ERR_DIVZ);
                res_r   <= '0;
                state_r <= S_PUSH;
              end else begin
                state_r <= S_WAIT;
              end
            end
            default: state_r <= S_PUSH;
          endcase
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            res_r   <= alu_rsp.result;
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (cnt_r < CW'(STACK_DEPTH)) begin
            cnt_r <= cnt_r + CW'(1);
          end else begin
            err_r <= raise_err(err_r, ERR_OVER);
          end
          state_r <= last_r ? S_FIN_RD : S_IDLE;
        end
        S_FIN_RD: begin
          // let the read of the new top of stack land
          state_r <= S_FIN_OUT;
        end
        S_FIN_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_value_r  <= (fin_err == ERR_NONE) ? rdata_r : '0;
            out_status_r <= fin_err;
            cnt_r        <= '0;
            err_r        <= ERR_NONE;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign alu_req.start  = alu_start_r;
  assign alu_req.is_div = (kind_r == K_DIV);
  assign alu_req.a      = alu_a_r;
  assign alu_req.b      = alu_b_r;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

endmodule

>>> design/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix evaluator on a Q32.32 operand stack: front classifier, command
// queue, stack sequencer and a multicycle multiply/divide unit.
// ----------------------------------------------------------------------------
// The block takes one character per item and gives one result (value and
// status) after each item marked last. Items pass through a two-entry command
// queue to the stack sequencer, so the input keeps accepting while an earlier
// item executes. The sequencer takes a new item from the queue only when it is
// done with the last: a digit is pushed; +, -, * and / pop the right and then
// the left operand, execute and push. * runs four 32x32 partial products in
// turn and / the restoring divider, which resolves one quotient bit a cycle
// over 64 bits; a quotient that overflows skips the loop, and a divide by zero
// pushes zero without the divider. A last item adds the final pop, which waits
// while an earlier result still waits at the output. Ignored characters that
// do not end the expression are dropped at the front, before the sequencer.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  pfe_in_if.sink    in_ch,
  pfe_out_if.source out_ch
);
  import pfe_pkg::*;

  logic     fe_valid, fe_ready;
  cmd_t     fe_cmd;
  logic     be_valid, be_ready;
  cmd_t     be_cmd;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  pfe_front u_front (
    .in_ch     (in_ch),
    .cmd_valid (fe_valid),
    .cmd       (fe_cmd),
    .cmd_ready (fe_ready)
  );

  pfe_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fe_valid),
    .wr_data  (fe_cmd),
    .wr_ready (fe_ready),
    .rd_valid (be_valid),
    .rd_data  (be_cmd),
    .rd_ready (be_ready)
  );

  pfe_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (be_valid),
    .cmd       (be_cmd),
    .cmd_ready (be_ready),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .out_ch    (out_ch)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the postfix expression evaluator. Characters are
// driven in bursts, results are drained under a changing stall pattern, and
// every result is compared with a Q32.32 stack evaluator kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import pfe_pkg::*;

  localparam int STACK_LIMIT  = 64;
  localparam int ITEM_TARGET  = 1150;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 200;

  localparam logic [SYM_W-1:0] CH_NUL = 8'h00;
  localparam logic [SYM_W-1:0] CH_TOP = 8'hFF;

  typedef logic [SYM_W-1:0] sym_q_t[$];

  typedef struct {
    logic [VAL_W-1:0] value;
    err_t             status;
  } answer_t;

  logic clk;
  logic rst_n;

  pfe_in_if  in_ch ();
  pfe_out_if out_ch ();

  postfix_expression_evaluator #(
    .STACK_DEPTH (STACK_LIMIT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bench copy of the evaluator state
  logic [VAL_W-1:0] eval_stack[$];
  err_t             eval_err;
  answer_t          pending_answers[$];

  int cycle_count;
  int mismatches;
  int symbols_sent;
  int expressions_sent;
  int burst_left;
  int status_seen[4];

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_answers.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- arithmetic

  function automatic logic [VAL_W-1:0] magnitude_of(logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [VAL_W-1:0] clamp_signed(logic [VAL_W-1:0] m, bit neg,
                                                    bit ovf);
    logic [VAL_W-1:0] bound;
    bound = neg ? VAL_MIN : VAL_MAX;
    if (ovf || m > bound) m = bound;
    return neg ? (~m + 64'd1) : m;
  endfunction

  function automatic logic [VAL_W-1:0] add_sat(logic [VAL_W-1:0] a,
                                               logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] s;
    s = a + b;
    if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
      return a[VAL_W-1] ? VAL_MIN : VAL_MAX;
    return s;
  endfunction

  function automatic logic [VAL_W-1:0] sub_sat(logic [VAL_W-1:0] a,
                                               logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] d;
    d = a - b;
    if (a[VAL_W-1] != b[VAL_W-1] && d[VAL_W-1] != a[VAL_W-1])
      return a[VAL_W-1] ? VAL_MIN : VAL_MAX;
    return d;
  endfunction

  function automatic logic [VAL_W-1:0] mul_q32(logic [VAL_W-1:0] a,
                                               logic [VAL_W-1:0] b);
    logic [2*VAL_W-1:0] prod;
    prod = {64'd0, magnitude_of(a)} * {64'd0, magnitude_of(b)};
    return clamp_signed(prod[VAL_W+FRAC_W-1:FRAC_W], a[VAL_W-1] ^ b[VAL_W-1],
                        |prod[2*VAL_W-1:VAL_W+FRAC_W]);
  endfunction

  function automatic logic [VAL_W-1:0] div_q32(logic [VAL_W-1:0] a,
                                               logic [VAL_W-1:0] b);
    logic [2*VAL_W-1:0] num;
    logic [2*VAL_W-1:0] quot;
    num  = {32'd0, magnitude_of(a), 32'd0};
    quot = num / {64'd0, magnitude_of(b)};
    return clamp_signed(quot[VAL_W-1:0], a[VAL_W-1] ^ b[VAL_W-1],
                        |quot[2*VAL_W-1:VAL_W]);
  endfunction

  // ---------------------------------------------------------------- stack

  function automatic void flag_error(err_t code);
    if (eval_err == ERR_NONE) eval_err = code;
  endfunction

  function automatic void push_operand(logic [VAL_W-1:0] v);
    if (eval_stack.size() >= STACK_LIMIT) flag_error(ERR_OVER);
    else eval_stack.push_back(v);
  endfunction

  function automatic logic [VAL_W-1:0] pop_operand();
    if (eval_stack.size() == 0) begin
      flag_error(ERR_UNDER);
      return '0;
    end
    return eval_stack.pop_back();
  endfunction

  // Apply one accepted character; queue the answer when it closes an expression
  function automatic void evaluate_symbol(logic [SYM_W-1:0] sym, logic lst);
    logic [VAL_W-1:0] rhs;
    logic [VAL_W-1:0] lhs;
    logic [VAL_W-1:0] res;
    logic [SYM_W-1:0] dv;
    answer_t          ans;
    bit               is_op;
    is_op = (sym == CH_ADD || sym == CH_SUB || sym == CH_MUL || sym == CH_DIV);
    symbols_sent++;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      dv = sym - CH_ZERO;
      push_operand(64'(dv) << FRAC_W);
    end else if (is_op) begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (sym)
        CH_ADD:  res = add_sat(lhs, rhs);
        CH_SUB:  res = sub_sat(lhs, rhs);
        CH_MUL:  res = mul_q32(lhs, rhs);
        default: begin
          if (rhs == '0) begin
            flag_error(ERR_DIVZ);
            res = '0;
          end else begin
            res = div_q32(lhs, rhs);
          end
        end
      endcase
      push_operand(res);
    end
    if (lst) begin
      res        = pop_operand();
      ans.value  = (eval_err == ERR_NONE) ? res : '0;
      ans.status = eval_err;
      pending_answers.push_back(ans);
      eval_stack.delete();
      eval_err = ERR_NONE;
      expressions_sent++;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %h status %0d",
                 $time, out_ch.value, out_ch.status);
        mismatches++;
      end else begin
        exp_ans = pending_answers.pop_front();
        status_seen[exp_ans.status]++;
        if (out_ch.value !== exp_ans.value) begin
          $display("%0t: value mismatch: expected %h, actual %h", $time,
                   exp_ans.value, out_ch.value);
          mismatches++;
        end
        if (out_ch.status !== exp_ans.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   exp_ans.status, out_ch.status);
          mismatches++;
        end
      end
    end
  end

  // Result side: cycle through always-ready, random and sparse patterns
  initial begin
    int phase_cycle;
    phase_cycle  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      phase_cycle++;
      case ((phase_cycle / 250) % 4)
        0:       out_ch.ready = 1'b1;
        1:       out_ch.ready = ($urandom_range(0, 1) == 1);
        2:       out_ch.ready = (phase_cycle % 5 == 0);
        default: out_ch.ready = ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic logic [SYM_W-1:0] digit_ch(int n);
    return CH_ZERO + SYM_W'(n);
  endfunction

  task automatic new_burst();
    if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(50, 150);
    else burst_left = $urandom_range(1, 20);
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic lst);
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.symbol = sym;
    in_ch.last   = lst;
    do @(posedge clk); while (!in_ch.ready);
    evaluate_symbol(sym, lst);
    burst_left--;
    if (burst_left <= 0) begin
      // drop valid and idle before the next burst
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      new_burst();
    end
  endtask

  task automatic send_expr(input sym_q_t q);
    foreach (q[i]) send_symbol(q[i], i == q.size() - 1);
  endtask

  // Repeated multiply drives the value toward the saturation bound
  task automatic grow_chain(ref sym_q_t q);
    q.push_back(digit_ch(9));
    repeat ($urandom_range(1, 14)) begin
      q.push_back(digit_ch($urandom_range(2, 9)));
      q.push_back(CH_MUL);
    end
  endtask

  task automatic add_operand(ref sym_q_t q);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      q.push_back(digit_ch($urandom_range(0, 9)));
    end else if (pick < 70) begin
      grow_chain(q);
    end else if (pick < 82) begin
      // repeated divide shrinks toward the smallest step, or to zero
      q.push_back(digit_ch($urandom_range(1, 9)));
      repeat ($urandom_range(1, 12)) begin
        q.push_back(digit_ch($urandom_range(2, 9)));
        q.push_back(CH_DIV);
      end
    end else begin
      q.push_back(digit_ch(0));
      if ($urandom_range(0, 1) == 1) grow_chain(q);
      else q.push_back(digit_ch($urandom_range(0, 9)));
      q.push_back(CH_SUB);
    end
  endtask

  task automatic build_expression(ref sym_q_t q);
    int               depth;
    int               ops_left;
    int               pos;
    logic [SYM_W-1:0] ops[4];
    ops      = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};
    depth    = 0;
    ops_left = $urandom_range(1, 10);
    q.delete();
    while (ops_left > 0 || depth > 1) begin
      if ($urandom_range(0, 99) < 5) q.push_back(SYM_W'($urandom_range(0, 255)));
      if (depth < 2 || (ops_left > 0 && $urandom_range(0, 1) == 1)) begin
        add_operand(q);
        depth++;
      end else begin
        q.push_back(ops[$urandom_range(0, 3)]);
        depth--;
        if (ops_left > 0) ops_left--;
      end
    end
    // Break a few expressions: lose a character, add an operator or a leftover
    case ($urandom_range(0, 19))
      0: begin
        pos = $urandom_range(0, q.size() - 1);
        q.delete(pos);
        if (q.size() == 0) q.push_back(CH_ADD);
      end
      1: q.insert($urandom_range(0, q.size()), ops[$urandom_range(0, 3)]);
      2: q.insert($urandom_range(0, q.size() - 1), digit_ch($urandom_range(0, 9)));
      default: ;
    endcase
    // Sometimes end on a character that is ignored
    case ($urandom_range(0, 9))
      0: q.push_back(CH_NUL);
      1: q.push_back(SYM_W'($urandom_range(128, 255)));
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_operators();
    sym_q_t e;
    e = '{digit_ch(3), digit_ch(4), CH_ADD};
    send_expr(e);
    e = '{digit_ch(2), digit_ch(7), CH_SUB};
    send_expr(e);
    e = '{digit_ch(9), digit_ch(8), CH_MUL};
    send_expr(e);
    e = '{digit_ch(7), digit_ch(3), CH_DIV};
    send_expr(e);
    // negative quotient truncates toward zero
    e = '{digit_ch(0), digit_ch(7), CH_SUB, digit_ch(3), CH_DIV};
    send_expr(e);
  endtask

  task automatic test_error_cases();
    sym_q_t e;
    e = '{digit_ch(5), digit_ch(0), CH_DIV};
    send_expr(e);
    e = '{CH_ADD};
    send_expr(e);
    e = '{digit_ch(5), CH_NUL};
    send_expr(e);
    e = '{CH_TOP};
    send_expr(e);
    e = '{digit_ch(1), digit_ch(2)};
    send_expr(e);
  endtask

  // Fill the stack to around its depth so that pushes can overflow
  task automatic test_deep_stack();
    sym_q_t e;
    repeat (4) begin
      e.delete();
      repeat ($urandom_range(STACK_LIMIT - 2, STACK_LIMIT + 4))
        e.push_back(digit_ch($urandom_range(0, 9)));
      repeat ($urandom_range(0, 5)) e.push_back(CH_ADD);
      e.push_back(digit_ch($urandom_range(0, 9)));
      e.push_back(CH_MUL);
      send_expr(e);
    end
  endtask

  task automatic test_noise();
    repeat (60)
      send_symbol(SYM_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    send_symbol(digit_ch(1), 1'b1);
  endtask

  task automatic test_random_expressions();
    sym_q_t e;
    while (symbols_sent < ITEM_TARGET) begin
      build_expression(e);
      send_expr(e);
    end
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.symbol     = '0;
    in_ch.last       = 1'b0;
    cycle_count      = 0;
    mismatches       = 0;
    symbols_sent     = 0;
    expressions_sent = 0;
    eval_err         = ERR_NONE;
    status_seen      = '{0, 0, 0, 0};
    new_burst();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_operators();
    test_error_cases();
    test_deep_stack();
    test_noise();
    test_random_expressions();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d expressions over %0d symbols evaluated", expressions_sent,
             symbols_sent);
    $display("tb: status counts ok %0d, underflow %0d, overflow %0d, div by zero %0d",
             status_seen[ERR_NONE], status_seen[ERR_UNDER], status_seen[ERR_OVER],
             status_seen[ERR_DIVZ]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/pfe_pkg.sv
design/pfe_if.sv
design/pfe_front.sv
design/pfe_cmd_fifo.sv
design/pfe_alu.sv
design/pfe_back.sv
design/postfix_expression_evaluator.sv
bench/testbench.sv
